@@ sv/dsts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dsts_pkg;

  // Field widths fixed by the sensor and ADC interface
  localparam int unsigned INTEG_W  = 20;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 21;
  localparam int unsigned CFG_IDX_W = 2;

  // Lead periods with start low before integration
  localparam int unsigned LEAD_CLOCKS = 2;

  // Defaults for the top-level parameters
  localparam int unsigned PAUSE_CLOCKS_DEF = 87;
  localparam int unsigned CHANNELS_DEF     = 288;

  // Integration register reset value
  localparam logic [INTEG_W-1:0] INTEG_RST = INTEG_W'(100);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_B = CFG_IDX_W'(1);

  // Run phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEQ  = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;

  // Control from the sequencer to one sensor lane
  typedef struct packed {
    logic seq_en;   // advance the count this period
    logic restart;  // a run starts this period: count reads as zero
    logic clr;      // run ends: clear the count
  } lane_ctrl_t;

  // Status from one sensor lane for the current period
  typedef struct packed {
    logic pulse;
    logic level;
    logic done;     // sequence complete after this period
  } lane_stat_t;

  // One result word
  typedef struct packed {
    logic                clk_a_pulse;
    logic                clk_b_pulse;
    logic                start_a_level;
    logic                start_b_level;
    logic                video_valid;
    logic [SAMPLE_W-1:0] video_a;
    logic [SAMPLE_W-1:0] video_b;
    logic                last_channel;
    logic                busy_res;
  } res_t;

endpackage

`default_nettype wire

@@ sv/dsts_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input word channel: one sensor clock period
interface dsts_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [dsts_pkg::SAMPLE_W-1:0] sample_a;
  logic [dsts_pkg::SAMPLE_W-1:0] sample_b;

  modport source (output valid, cmd, sample_a, sample_b, input ready);
  modport sink   (input valid, cmd, sample_a, sample_b, output ready);
endinterface

// Result word channel
interface dsts_out_if;
  logic                          valid;
  logic                          ready;
  logic                          clk_a_pulse;
  logic                          clk_b_pulse;
  logic                          start_a_level;
  logic                          start_b_level;
  logic                          video_valid;
  logic [dsts_pkg::SAMPLE_W-1:0] video_a;
  logic [dsts_pkg::SAMPLE_W-1:0] video_b;
  logic                          last_channel;
  logic                          busy_res;

  modport source (output valid, clk_a_pulse, clk_b_pulse, start_a_level, start_b_level,
                  video_valid, video_a, video_b, last_channel, busy_res,
                  input ready);
  modport sink   (input valid, clk_a_pulse, clk_b_pulse, start_a_level, start_b_level,
                  video_valid, video_a, video_b, last_channel, busy_res,
                  output ready);
endinterface

// Configuration write channel
interface dsts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dsts_pkg::CFG_IDX_W-1:0] index;
  logic [dsts_pkg::INTEG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/dual_spectrometer_timing_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Timing sequencer for two linear spectrometer sensors. Every input word stands for one
// sensor clock period and yields exactly one result word; one word is taken per clock
// cycle, with a result register between input and output so a stalled output does not
// stop the next word until that register is full. A start command while idle opens a run
// in that same period: each sensor gets 2 lead pulses with start low, its integration
// count with start high, then PAUSE_CLOCKS pulses with start low; the sensor that ends
// first stops pulsing until the other is done. CHANNELS readout periods follow, passing
// both ADC samples through with both clocks pulsing; the last one is flagged. Starts while
// busy are dropped. Configuration index 0 sets the sensor A integration time, index 1
// sensor B; writes take effect immediately and other indexes are ignored.
module dual_spectrometer_timing_sequencer #(
  parameter int unsigned PAUSE_CLOCKS = dsts_pkg::PAUSE_CLOCKS_DEF,
  parameter int unsigned CHANNELS     = dsts_pkg::CHANNELS_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dsts_in_if.sink   in_i,
  dsts_out_if.source out_o,
  dsts_cfg_if.sink  cfg_i
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  logic [dsts_pkg::INTEG_W-1:0] integ_a_q, integ_b_q;
  logic [1:0]                   phase_q, phase_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic                         out_valid_q;
  dsts_pkg::res_t               res_q, res_d;

  logic                 acc;
  logic                 idle;
  logic                 start;
  logic                 in_seq;
  logic                 in_read;
  logic                 last_idx;
  dsts_pkg::lane_ctrl_t ctrl;
  dsts_pkg::lane_stat_t stat_a, stat_b;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_a_q <= dsts_pkg::INTEG_RST;
      integ_b_q <= dsts_pkg::INTEG_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == dsts_pkg::REG_INTEG_A) begin
        integ_a_q <= cfg_i.data;
      end else if (cfg_i.index == dsts_pkg::REG_INTEG_B) begin
        integ_b_q <= cfg_i.data;
      end
    end
  end

  // Take a word whenever the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  // Phase decode for the current word
  assign idle     = !(phase_q == dsts_pkg::PH_SEQ || phase_q == dsts_pkg::PH_READ);
  assign start    = idle && in_i.cmd;
  assign in_seq   = (phase_q == dsts_pkg::PH_SEQ) || start;
  assign in_read  = (phase_q == dsts_pkg::PH_READ);
  assign last_idx = (idx_q == IDX_LAST);

  assign ctrl.seq_en  = acc && in_seq;
  assign ctrl.restart = start;
  assign ctrl.clr     = acc && in_read && last_idx;

  dsts_lane #(.PAUSE_CLOCKS(PAUSE_CLOCKS)) u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .integ_i (integ_a_q),
    .ctrl_i  (ctrl),
    .stat_o  (stat_a)
  );

  dsts_lane #(.PAUSE_CLOCKS(PAUSE_CLOCKS)) u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .integ_i (integ_b_q),
    .ctrl_i  (ctrl),
    .stat_o  (stat_b)
  );

  // Merge lane status and readout data into one result word
  always_comb begin
    res_d               = '0;
    res_d.busy_res      = !idle || start;
    res_d.clk_a_pulse   = in_seq ? stat_a.pulse : in_read;
    res_d.clk_b_pulse   = in_seq ? stat_b.pulse : in_read;
    res_d.start_a_level = in_seq && stat_a.level;
    res_d.start_b_level = in_seq && stat_b.level;
    res_d.video_valid   = in_read;
    res_d.video_a       = in_read ? in_i.sample_a : '0;
    res_d.video_b       = in_read ? in_i.sample_b : '0;
    res_d.last_channel  = in_read && last_idx;
  end

  // Advance the run phase and readout index
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (acc) begin
      if (in_seq) begin
        phase_d = dsts_pkg::PH_SEQ;
        if (stat_a.done && stat_b.done) begin
          phase_d = dsts_pkg::PH_READ;
          idx_d   = '0;
        end
      end else if (in_read) begin
        if (last_idx) begin
          phase_d = dsts_pkg::PH_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end else begin
        phase_d = dsts_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dsts_pkg::PH_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.clk_a_pulse   = res_q.clk_a_pulse;
  assign out_o.clk_b_pulse   = res_q.clk_b_pulse;
  assign out_o.start_a_level = res_q.start_a_level;
  assign out_o.start_b_level = res_q.start_b_level;
  assign out_o.video_valid   = res_q.video_valid;
  assign out_o.video_a       = res_q.video_a;
  assign out_o.video_b       = res_q.video_b;
  assign out_o.last_channel  = res_q.last_channel;
  assign out_o.busy_res      = res_q.busy_res;

  // An idle word carries nothing but zeros
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.busy_res) |->
      (!out_o.clk_a_pulse && !out_o.clk_b_pulse && !out_o.video_valid &&
       !out_o.start_a_level && !out_o.start_b_level))
    else $error("idle result word is not all zero");

  // The last channel flag only appears on a readout word
  a_last_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_channel) |-> (out_o.video_valid && out_o.busy_res))
    else $error("last channel outside readout");

  // A start line high always comes with its clock pulse
  a_level_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.start_a_level || out_o.start_b_level)) |->
      ((!out_o.start_a_level || out_o.clk_a_pulse) &&
       (!out_o.start_b_level || out_o.clk_b_pulse)))
    else $error("start level without clock pulse");

  // Readout is entered only once both lanes have finished
  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && phase_q == dsts_pkg::PH_SEQ && phase_d == dsts_pkg::PH_READ) |->
      (stat_a.done && stat_b.done))
    else $error("readout entered before both sensors finished");

endmodule

`default_nettype wire

@@ sv/dsts_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One sensor lane: period counter, clock gate and start line level
module dsts_lane #(
  parameter int unsigned PAUSE_CLOCKS = dsts_pkg::PAUSE_CLOCKS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [dsts_pkg::INTEG_W-1:0] integ_i,
  input  wire dsts_pkg::lane_ctrl_t         ctrl_i,
  output dsts_pkg::lane_stat_t              stat_o
);

  localparam int unsigned CW = dsts_pkg::CNT_W;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] integ_end;
  logic [CW-1:0] total;
  logic          active;

  // Sequence boundaries for the current integration time
  assign integ_end = CW'(dsts_pkg::LEAD_CLOCKS) + CW'(integ_i);
  assign total     = integ_end + CW'(PAUSE_CLOCKS);

  // Count seen this period: zero on the first period of a run
  assign cnt_cur = ctrl_i.restart ? '0 : cnt_q;
  assign active  = (cnt_cur < total);
  assign cnt_nxt = active ? cnt_cur + CW'(1) : cnt_cur;

  assign stat_o.pulse = active;
  assign stat_o.level = active && (cnt_cur >= CW'(dsts_pkg::LEAD_CLOCKS)) &&
                        (cnt_cur < integ_end);
  assign stat_o.done  = (cnt_nxt >= total);

  // Advance while sequencing, drop to zero at the end of a run
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clr) begin
      cnt_d = '0;
    end else if (ctrl_i.seq_en) begin
      cnt_d = cnt_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire
